FILE: rtl/core/nfcd_pkg.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder package
// Shared widths, command codes, event codes and item structs.
// ----------------------------------------------------------------------------
package nfcd_pkg;

   // Address handling.
   localparam int ADDR_W            = 23;
   localparam int DATA_W            = 16;
   localparam int WORD_ADDRESS_BITS = 23;
   localparam int SECTOR_WORD_BITS  = 15;
   localparam int CMD_ADDR_BITS     = 11;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      ADDR_W'((64'd1 << WORD_ADDRESS_BITS) - 64'd1);

   // Unlock addresses, compared on the low command address bits.
   localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR_1 = 11'h555;
   localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR_2 = 11'h2AA;

   // Autoselect ID word addresses.
   localparam logic [ADDR_W-1:0] ID_ADDR_DEVICE   = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] ID_ADDR_EXTENDED = ADDR_W'(14);

   // Command data words.
   localparam logic [DATA_W-1:0] CMD_UNLOCK_1   = 16'h00AA;
   localparam logic [DATA_W-1:0] CMD_UNLOCK_2   = 16'h0055;
   localparam logic [DATA_W-1:0] CMD_AUTOSELECT = 16'h0090;
   localparam logic [DATA_W-1:0] CMD_RESET      = 16'h00F0;
   localparam logic [DATA_W-1:0] CMD_ERASE_SETUP = 16'h0080;
   localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 16'h0030;
   localparam logic [DATA_W-1:0] CMD_PROGRAM    = 16'h00A0;

   // Reset values of the ID registers.
   localparam logic [DATA_W-1:0] DEVICE_ID_RESET   = 16'h227E;
   localparam logic [DATA_W-1:0] EXTENDED_ID_RESET = 16'h2221;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_DEVICE_ID   = 1'b0,
      CSR_EXTENDED_ID = 1'b1
   } csr_index_type;

   // Bus access kinds.
   typedef enum logic [0:0] {
      ACC_READ  = 1'b0,
      ACC_WRITE = 1'b1
   } access_type;

   // Result events.
   typedef enum logic [2:0] {
      EV_ACCEPT     = 3'd0,
      EV_ARRAY_READ = 3'd1,
      EV_ID_READ    = 3'd2,
      EV_PROGRAM    = 3'd3,
      EV_ERASE      = 3'd4,
      EV_RESET      = 3'd5,
      EV_AUTOSELECT = 3'd6,
      EV_ERROR      = 3'd7
   } event_type;

   typedef struct packed {
      access_type        command;
      logic [ADDR_W-1:0] word_address;
      logic [DATA_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      event_type         event_res;
      logic [ADDR_W-1:0] target_address;
      logic [DATA_W-1:0] out_data;
   } rsp_item_type;

endpackage

FILE: rtl/core/nfcd_decoder.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder core
// Decodes one registered bus access into one event and updates the
// command sequence state when the word moves on to the result register.
// ----------------------------------------------------------------------------
module nfcd_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  nfcd_pkg::req_item_type item,
   input  logic [15:0]           device_id,
   input  logic [15:0]           extended_id,
   output nfcd_pkg::rsp_item_type result
);
   import nfcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE         = 3'd0,
      ST_AA_SEEN      = 3'd1,
      ST_UNLOCKED     = 3'd2,
      ST_PROG_PENDING = 3'd3,
      ST_ERASE_SETUP  = 3'd4,
      ST_ERASE_AA     = 3'd5,
      ST_ERASE_55     = 3'd6
   } step_type;

   step_type step_ff, step_in;
   logic     autosel_ff, autosel_in;

   logic [ADDR_W-1:0]        addr;
   logic [CMD_ADDR_BITS-1:0] low;
   logic                     at555, at2aa;
   logic [DATA_W-1:0]        data;

   assign addr  = item.word_address & ADDR_MASK;
   assign low   = addr[CMD_ADDR_BITS-1:0];
   assign at555 = (low == UNLOCK_ADDR_1);
   assign at2aa = (low == UNLOCK_ADDR_2);
   assign data  = item.write_data;

   // Next state and result for the current access.
   always_comb begin
      step_in               = step_ff;
      autosel_in            = autosel_ff;
      result.event_res      = EV_ERROR;
      result.target_address = '0;
      result.out_data       = '0;

      if (item.command == ACC_READ) begin
         // Reads never move the command sequence.
         result.target_address = addr;
         if (autosel_ff) begin
            result.event_res = EV_ID_READ;
            if (addr == ID_ADDR_DEVICE) begin
               result.out_data = device_id;
            end else if (addr == ID_ADDR_EXTENDED) begin
               result.out_data = extended_id;
            end
         end else begin
            result.event_res = EV_ARRAY_READ;
         end
      end else if (data == CMD_RESET) begin
         step_in          = ST_IDLE;
         autosel_in       = 1'b0;
         result.event_res = EV_RESET;
      end else begin
         // Anything not matched below is an out of sequence write.
         step_in = ST_IDLE;
         case (step_ff)
            ST_AA_SEEN: begin
               if (data == CMD_UNLOCK_2 && at2aa) begin
                  step_in          = ST_UNLOCKED;
                  result.event_res = EV_ACCEPT;
               end
            end
            ST_UNLOCKED: begin
               if (at555 && data == CMD_AUTOSELECT) begin
                  autosel_in       = 1'b1;
                  result.event_res = EV_AUTOSELECT;
               end else if (at555 && data == CMD_PROGRAM) begin
                  step_in          = ST_PROG_PENDING;
                  result.event_res = EV_ACCEPT;
               end else if (at555 && data == CMD_ERASE_SETUP) begin
                  step_in          = ST_ERASE_SETUP;
                  result.event_res = EV_ACCEPT;
               end
            end
            ST_PROG_PENDING: begin
               result.event_res      = EV_PROGRAM;
               result.target_address = addr;
               result.out_data       = data;
            end
            ST_ERASE_SETUP: begin
               if (data == CMD_UNLOCK_1 && at555) begin
                  step_in          = ST_ERASE_AA;
                  result.event_res = EV_ACCEPT;
               end
            end
            ST_ERASE_AA: begin
               if (data == CMD_UNLOCK_2 && at2aa) begin
                  step_in          = ST_ERASE_55;
                  result.event_res = EV_ACCEPT;
               end
            end
            ST_ERASE_55: begin
               if (data == CMD_SECTOR_ERASE) begin
                  result.event_res      = EV_ERASE;
                  result.target_address = addr >> SECTOR_WORD_BITS;
               end
            end
            default: begin
               if (data == CMD_UNLOCK_1 && at555) begin
                  step_in          = ST_AA_SEEN;
                  result.event_res = EV_ACCEPT;
               end
            end
         endcase
      end
   end

   // Sequence state commits only when the access is handed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_IDLE;
         autosel_ff <= 1'b0;
      end else if (advance) begin
         step_ff    <= step_in;
         autosel_ff <= autosel_in;
      end
   end

endmodule

FILE: rtl/core/nor_flash_command_decoder_top.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder top level
// Input word register, command decoder and result register with handshakes.
// ----------------------------------------------------------------------------
// An accepted word waits in the input register; its result is registered in the result register for rsp_.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when rsp_tready is held low.
// Reset (synchronous, active high) empties both stages, returns the command
// sequence to idle with autoselect off, and loads the default ID words.
module nor_flash_command_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // word_address[22:0], write_data[38:23], zero pad
   input  logic [0:0]  req_tuser,   // command[0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // target_address[22:0], out_data[38:23], zero pad
   output logic [2:0]  rsp_tuser,   // event_res[2:0]
   // Configuration writes.
   input  logic        csr_we,
   input  nfcd_pkg::csr_index_type csr_index,
   input  logic [15:0] csr_wdata
);
   import nfcd_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type decoded;
   logic         advance;
   logic [15:0]  device_id_ff;
   logic [15:0]  extended_id_ff;

   // The input stage moves on whenever the result register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.command      <= access_type'(req_tuser[0]);
         in_item_ff.word_address <= req_tdata[ADDR_W-1:0];
         in_item_ff.write_data   <= req_tdata[ADDR_W+DATA_W-1:ADDR_W];
      end
   end

   nfcd_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .device_id   (device_id_ff),
      .extended_id (extended_id_ff),
      .result      (decoded)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= decoded;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.event_res;
   assign rsp_tdata  = {1'b0, out_item_ff.out_data, out_item_ff.target_address};

   // ID registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff   <= DEVICE_ID_RESET;
         extended_id_ff <= EXTENDED_ID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ID:   device_id_ff   <= csr_wdata;
            CSR_EXTENDED_ID: extended_id_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The pad bit of the request word carries nothing.
   logic unused_pad;
   assign unused_pad = req_tdata[39];

endmodule
